// ----- sv/ptmbs_pkg.sv -----
// Package for the page to module binary search block.
// Holds the sequencer state type, command and register codes, and port widths.
// No dependencies.
`default_nettype none

package ptmbs_pkg;

    // Default sizing of the offset table.
    localparam int MAX_MODULES_DEF = 4096;
    localparam int OFFSET_BITS_DEF = 31;

    // Field widths of the transactions.
    localparam int ENTRY_IDX_W  = 12;
    localparam int ENTRY_OFS_W  = 32;
    localparam int PAGE_W       = 24;
    localparam int MOD_IDX_W    = 12;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 16;

    // Configuration registers.
    localparam int PAGE_SIZE_W  = 17;
    localparam int MOD_COUNT_W  = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 17;
    localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RST = 17'd16;
    localparam logic [MOD_COUNT_W-1:0] MOD_COUNT_RST = 13'd0;
    localparam logic [CFG_IDX_W-1:0]   CFG_PAGE_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0]   CFG_MODULE_COUNT = 1'b1;

    // Target byte offset: page number times page size, kept at full width.
    localparam int TGT_W = PAGE_W + PAGE_SIZE_W;

    // Command carried in tuser.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Search sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- sv/ptmbs_table.sv -----
// Offset table memory: one write port and one registered read port.
// Contents are not reset. No dependencies.
`default_nettype none

module ptmbs_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/page_to_module_binary_search.sv -----
// Sequence: a write transaction updates the table as it is accepted. A lookup makes its table
// probes one after another, at most clog2(count + 1) probes (13 for 4096 entries), as the single
// table read port allows, then waits until the output register is free and loads the result.
// Throughput: one lookup at a time; the input is ready again once the result is registered.
// Reset (synchronous, active low) clears the sequencer and output valid and sets page size
// to 16 and module count to 0; the offset table contents are not cleared.
`default_nettype none

module page_to_module_binary_search #(
    parameter int MAX_MODULES = ptmbs_pkg::MAX_MODULES_DEF,
    parameter int OFFSET_BITS = ptmbs_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [ptmbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ptmbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, low bit up: entry_index[11:0], entry_offset[43:12], page_number[67:44], zeros
    input  wire logic [ptmbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // tuser: cmd
    input  wire logic [0:0]                        s_axis_tuser,
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata, low bit up: module_index[11:0], zeros
    output logic      [ptmbs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // tuser: found
    output logic      [0:0]                        m_axis_tuser
);

    import ptmbs_pkg::*;

    localparam int AW    = $clog2(MAX_MODULES);
    localparam int CNT_W = $clog2(MAX_MODULES + 1);

    // Registers
    t_state                 r_state, n_state;
    logic [PAGE_SIZE_W-1:0] r_page_bytes;
    logic [MOD_COUNT_W-1:0] r_module_count;
    logic [TGT_W-1:0]       r_target, n_target;
    logic [CNT_W-1:0]       r_low, n_low;
    logic [CNT_W-1:0]       r_high, n_high;
    logic [CNT_W-1:0]       r_probe, n_probe;
    logic [MOD_IDX_W-1:0]   r_res_idx, n_res_idx;
    logic                   r_res_found, n_res_found;
    logic                   r_out_valid, n_out_valid;
    logic [MOD_IDX_W-1:0]   r_out_idx, n_out_idx;
    logic                   r_out_found, n_out_found;

    // Input fields
    logic                   w_in_acc;
    logic                   w_cmd;
    logic [ENTRY_IDX_W-1:0] w_widx;
    logic [ENTRY_OFS_W-1:0] w_wofs;
    logic [PAGE_W-1:0]      w_page;
    logic [31:0]            w_widx_ext;
    logic                   w_widx_ok;

    // Search datapath
    logic [31:0]            w_mc_ext;
    logic [CNT_W-1:0]       w_count;
    logic [CNT_W-1:0]       w_first_probe;
    logic [TGT_W-1:0]       w_product;
    logic [TGT_W-1:0]       w_entry;
    logic                   w_less;
    logic                   w_equal;
    logic [CNT_W-1:0]       w_nlow;
    logic [CNT_W-1:0]       w_nhigh;
    logic [CNT_W-1:0]       w_nmid;
    logic [31:0]            w_probe_ext;

    // Table ports
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic [OFFSET_BITS-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [AW-1:0]          w_rd_addr;
    logic [OFFSET_BITS-1:0] w_rd_data;

    ptmbs_table #(
        .DEPTH (MAX_MODULES),
        .AW    (AW),
        .DW    (OFFSET_BITS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Unpack the input transaction.
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_cmd         = s_axis_tuser[0];
    assign w_widx        = s_axis_tdata[ENTRY_IDX_W-1:0];
    assign w_wofs        = s_axis_tdata[ENTRY_IDX_W+ENTRY_OFS_W-1:ENTRY_IDX_W];
    assign w_page        = s_axis_tdata[ENTRY_IDX_W+ENTRY_OFS_W+PAGE_W-1:
                                        ENTRY_IDX_W+ENTRY_OFS_W];
    assign w_widx_ext    = 32'(w_widx);
    assign w_widx_ok     = (w_widx_ext < 32'(MAX_MODULES));
    assign w_wr_addr     = w_widx_ext[AW-1:0];
    assign w_wr_data     = w_wofs[OFFSET_BITS-1:0];

    // Entry count, saturated to the table depth.
    assign w_mc_ext      = 32'(r_module_count);
    assign w_count       = (w_mc_ext > 32'(MAX_MODULES)) ? CNT_W'(MAX_MODULES)
                                                         : CNT_W'(r_module_count);
    assign w_first_probe = w_count >> 1;
    assign w_product     = TGT_W'(w_page) * TGT_W'(r_page_bytes);

    // Compare the probed entry and narrow the window [low, high).
    assign w_entry     = TGT_W'(w_rd_data);
    assign w_less      = (w_entry < r_target);
    assign w_equal     = (w_entry == r_target);
    assign w_nlow      = w_less ? (r_probe + CNT_W'(1)) : r_low;
    assign w_nhigh     = w_less ? r_high : r_probe;
    assign w_nmid      = w_nlow + ((w_nhigh - w_nlow) >> 1);
    assign w_probe_ext = 32'(r_probe);

    // Sequencer: next state, table accesses and result capture.
    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_low       = r_low;
        n_high      = r_high;
        n_probe     = r_probe;
        n_res_idx   = r_res_idx;
        n_res_found = r_res_found;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_idx   = r_out_idx;
        n_out_found = r_out_found;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_first_probe[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_cmd == CMD_WRITE) begin
                        w_wr_en = w_widx_ok;
                    end else begin
                        n_target = w_product;
                        n_low    = '0;
                        n_high   = w_count;
                        n_probe  = w_first_probe;
                        if (w_count == '0) begin
                            n_res_idx   = '0;
                            n_res_found = 1'b0;
                            n_state     = S_DONE;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_PROBE;
                        end
                    end
                end
            end
            S_PROBE: begin
                n_low  = w_nlow;
                n_high = w_nhigh;
                if (w_equal) begin
                    n_res_idx   = w_probe_ext[MOD_IDX_W-1:0];
                    n_res_found = 1'b1;
                    n_state     = S_DONE;
                end else if (w_nlow == w_nhigh) begin
                    n_res_idx   = '0;
                    n_res_found = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_nmid[AW-1:0];
                    n_probe   = w_nmid;
                end
            end
            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_res_idx;
                    n_out_found = r_res_found;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_page_bytes   <= PAGE_SIZE_RST;
            r_module_count <= MOD_COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PAGE_SIZE:    r_page_bytes   <= i_cfg_data[PAGE_SIZE_W-1:0];
                    CFG_MODULE_COUNT: r_module_count <= i_cfg_data[MOD_COUNT_W-1:0];
                    default:          r_page_bytes   <= r_page_bytes;
                endcase
            end
        end
    end

    // Search and result payload registers.
    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_low       <= n_low;
        r_high      <= n_high;
        r_probe     <= n_probe;
        r_res_idx   <= n_res_idx;
        r_res_found <= n_res_found;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
    end

    // Output transaction.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out_idx);
    assign m_axis_tuser  = r_out_found;

    // The search window is never empty while a probe is outstanding.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> (r_low < r_high))
        else $error("empty search window during a probe");

    // The outstanding probe lies inside the current window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE) |-> ((r_probe >= r_low) && (r_probe < r_high)))
        else $error("probe outside the search window");

    // A table write transaction leaves the sequencer idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (w_cmd == CMD_WRITE)) |=> (r_state == S_IDLE))
        else $error("write transaction started a search");

    // A not-found result carries index zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (r_out_idx == '0))
        else $error("not-found result with a non-zero index");

endmodule

`default_nettype wire

// ----- tb/page_to_module_binary_search_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the page to module binary search block.
// A scoreboard class predicts every lookup from its own copy of the offset table and
// registers. Depends on ptmbs_pkg and page_to_module_binary_search.

module page_to_module_binary_search_tb;
    import ptmbs_pkg::*;

    localparam int TABLE_DEPTH   = MAX_MODULES_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 30;

    // One lookup answer as the block should give it.
    typedef struct packed {
        logic [MOD_IDX_W-1:0] module_index;
        logic                 found;
    } t_lookup;

    // Scoreboard: keeps the table and registers and the queue of predicted answers.
    class page_lookup_board;
        logic [OFFSET_BITS_DEF-1:0] offsets [TABLE_DEPTH];
        logic [PAGE_SIZE_W-1:0]     page_bytes   = PAGE_SIZE_RST;
        logic [MOD_COUNT_W-1:0]     module_count = MOD_COUNT_RST;
        t_lookup                    expected_lookups [$];
        int                         mismatches = 0;
        int                         lookups    = 0;
        int                         hits       = 0;
        int                         writes     = 0;

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_PAGE_SIZE) begin
                page_bytes = data[PAGE_SIZE_W-1:0];
            end else if (idx == CFG_MODULE_COUNT) begin
                module_count = data[MOD_COUNT_W-1:0];
            end
        endfunction

        // Binary search of the first module_count entries for page * page_bytes.
        function t_lookup resolve_page(logic [PAGE_W-1:0] page);
            logic [TGT_W-1:0] target;
            int               lo;
            int               hi;
            int               probe;
            t_lookup          res;
            target = TGT_W'(page) * TGT_W'(page_bytes);
            hi     = (module_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(module_count);
            lo     = 0;
            res    = '0;
            while (hi != lo) begin
                probe = lo + (hi - lo) / 2;
                if (TGT_W'(offsets[probe]) < target) begin
                    lo = probe + 1;
                end else begin
                    hi = probe;
                    if (TGT_W'(offsets[probe]) == target) begin
                        res.module_index = probe[MOD_IDX_W-1:0];
                        res.found        = 1'b1;
                        break;
                    end
                end
            end
            return res;
        endfunction

        // Called at the edge where an input transaction is accepted.
        function void note_transaction(logic cmd, logic [ENTRY_IDX_W-1:0] idx,
                                       logic [ENTRY_OFS_W-1:0] ofs, logic [PAGE_W-1:0] page);
            t_lookup res;
            if (cmd == CMD_WRITE) begin
                offsets[idx] = ofs[OFFSET_BITS_DEF-1:0];
                writes++;
            end else begin
                res = resolve_page(page);
                expected_lookups.push_back(res);
                lookups++;
                if (res.found) hits++;
            end
        endfunction

        // Called at the edge where an output transaction is accepted.
        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [0:0] tuser);
            t_lookup want;
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result, module_index %0d found %0b",
                         $time, tdata[MOD_IDX_W-1:0], tuser[0]);
                mismatches++;
                return;
            end
            want = expected_lookups.pop_front();
            if (tdata[MOD_IDX_W-1:0] !== want.module_index) begin
                $display("%0t: module_index expected %0d, got %0d",
                         $time, want.module_index, tdata[MOD_IDX_W-1:0]);
                mismatches++;
            end
            if (tuser[0] !== want.found) begin
                $display("%0t: found expected %0b, got %0b", $time, want.found, tuser[0]);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int                    send_idle_pct = 24;
    int                    recv_idle_pct = 46;
    int unsigned           cycle_count   = 0;
    // Page number whose offset each table entry holds in the current phase.
    int unsigned           page_of [TABLE_DEPTH];

    page_lookup_board board = new();

    always #2 i_clk = ~i_clk;

    page_to_module_binary_search i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Receiver: checks accepted results and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Presents one transaction after a random gap and waits for it to be taken.
    task automatic send_transaction(logic cmd, logic [ENTRY_IDX_W-1:0] idx,
                                    logic [ENTRY_OFS_W-1:0] ofs, logic [PAGE_W-1:0] page);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({page, ofs, idx});
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_transaction(cmd, idx, ofs, page);
    endtask

    task automatic store(logic [ENTRY_IDX_W-1:0] idx, logic [ENTRY_OFS_W-1:0] ofs);
        send_transaction(CMD_WRITE, idx, ofs, PAGE_W'($urandom));
    endtask

    task automatic lookup(logic [PAGE_W-1:0] page);
        send_transaction(CMD_LOOKUP, ENTRY_IDX_W'($urandom), $urandom, page);
    endtask

    // Holds the input off until every predicted answer has been received.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (board.expected_lookups.size() != 0) @(posedge i_clk);
    endtask

    // Lets the last transaction finish inside the block before registers change.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes page size, then module count, one after the other.
    task automatic set_registers(logic [PAGE_SIZE_W-1:0] ps, logic [CFG_DATA_W-1:0] count_data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_PAGE_SIZE;
        i_cfg_data <= CFG_DATA_W'(ps);
        @(posedge i_clk);
        board.write_register(CFG_PAGE_SIZE, CFG_DATA_W'(ps));
        i_cfg_idx  <= CFG_MODULE_COUNT;
        i_cfg_data <= count_data;
        @(posedge i_clk);
        board.write_register(CFG_MODULE_COUNT, count_data);
        i_cfg_we   <= 1'b0;
    endtask

    // Loads entries 0 to count-1 with rising multiples of the page size; bit 31 is random.
    task automatic fill_table(int count, logic [PAGE_SIZE_W-1:0] ps);
        longint unsigned limit_m;
        longint unsigned m;
        int unsigned     gap;
        limit_m = 64'hFF_FFFF;
        if (ps != 0 && (64'h7FFF_FFFF / ps) < limit_m) limit_m = 64'h7FFF_FFFF / ps;
        gap = int'(limit_m / (count + 1));
        if (gap == 0) gap = 1;
        m = 0;
        for (int k = 0; k < count; k++) begin
            m += (k == 0) ? $urandom_range(0, gap) : $urandom_range(1, gap);
            page_of[k] = int'(m);
            store(ENTRY_IDX_W'(k), {1'($urandom), 31'(m * ps)});
        end
    endtask

    // One setting: registers, a fresh sorted table, then mostly well-formed lookups.
    task automatic run_phase(logic [PAGE_SIZE_W-1:0] ps, logic [MOD_COUNT_W-1:0] count);
        int              used;
        int              k;
        int              r;
        logic [PAGE_W-1:0] page;
        used = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
        set_registers(ps, {4'($urandom), count});
        fill_table(used, ps);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_results();
            r    = $urandom_range(0, 99);
            k    = (used > 0) ? $urandom_range(0, used - 1) : 0;
            page = PAGE_W'($urandom);
            if (r >= 85) begin
                // Rewrites keep the order; the odd wild write is noise.
                if (r < 93 && used > 0) begin
                    store(ENTRY_IDX_W'(k), {1'($urandom), 31'(page_of[k] * ps)});
                end else begin
                    store(ENTRY_IDX_W'($urandom), $urandom);
                end
            end else begin
                if (used > 0 && r < 55) begin
                    page = PAGE_W'(page_of[k]);
                end else if (used > 0 && r < 70) begin
                    page = PAGE_W'(page_of[k] + 1 - 2 * $urandom_range(0, 1));
                end
                lookup(page);
            end
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: an empty table finds nothing.
        lookup(24'h00_0000);
        lookup(24'hFF_FFFF);

        // Small table with bit 31 set on some entries, plus a write far beyond the count.
        store(12'd0, 32'h8000_0000);
        store(12'd1, 32'h0000_0010);
        store(12'd2, 32'h8000_0020);
        store(12'd3, 32'h0000_1000);
        store(12'd4, 32'h0FFF_FFF0);
        store(12'hFFF, 32'hFFFF_FFFF);
        settle();
        set_registers(17'd16, CFG_DATA_W'(5));
        lookup(24'h00_0000);
        lookup(24'h00_0001);
        lookup(24'h00_0002);
        lookup(24'h00_0100);
        lookup(24'hFF_FFFF);
        lookup(24'h00_0003);
        lookup(24'h7F_FFFF);
        settle();

        // A zero page size always targets offset zero.
        set_registers(17'd0, CFG_DATA_W'(5));
        lookup(24'h12_3456);
        settle();

        // Widest page size: the product overruns the entry range.
        set_registers(17'h1_FFFF, CFG_DATA_W'(5));
        lookup(24'hFF_FFFF);
        lookup(24'h00_0000);
        settle();

        // A count beyond the table depth is cut to 4096 entries. The entries on the
        // left-hand search path hold large offsets, so small targets stay inside them.
        for (int p = 8; p <= 2048; p = p * 2) begin
            store(ENTRY_IDX_W'(p), 32'hFFFF_FFFF);
        end
        settle();
        set_registers(17'd16, CFG_DATA_W'(8191));
        lookup(24'h00_0000);
        lookup(24'h00_0001);
        lookup(24'h00_0002);
        lookup(24'h00_0003);
        settle();

        // Random part, sender idling less than the receiver.
        run_phase(17'd1, 13'd32);
        run_phase(17'd16, 13'($urandom_range(1, 16)));
        run_phase(17'd0, 13'd7);

        // Receiver idling less than the sender.
        send_idle_pct = 46;
        recv_idle_pct = 24;
        run_phase(17'd65536, 13'd20);
        run_phase(17'($urandom_range(1, 65536)), 13'($urandom_range(1, 16)));
        run_phase(17'h1_FFFF, 13'd9);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(17'($urandom_range(1, 65536)), 13'd0);
        run_phase(17'($urandom_range(1, 65536)), 13'($urandom_range(1, 16)));
        run_phase(17'd3, 13'd2);

        board.mismatches += board.expected_lookups.size();
        $display("Ran %0d lookups (%0d predicted hits) and %0d table writes",
                 board.lookups, board.hits, board.writes);
        $display("over page sizes 0 to 131071, counts 0 to 8191 and three idling patterns.");
        if (board.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
